// ===== rtl/dtf_pkg.sv =====
`default_nettype none
package dtf_pkg;

    // number format limits
    localparam int unsigned MaxDigits = 8;
    localparam int unsigned MantW     = 27;
    localparam int unsigned CountW    = 4;

    // characters with a meaning
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // scale factors as binary32 exponent and significand with hidden bit
    localparam logic [7:0]  K_E_HUNDREDTH = 8'd120;
    localparam logic [23:0] K_M_HUNDREDTH = 24'hA3D70A;
    localparam logic [7:0]  K_E_TENTH     = 8'd123;
    localparam logic [23:0] K_M_TENTH     = 24'hCCCCCD;
    localparam logic [7:0]  K_E_TEN       = 8'd130;
    localparam logic [23:0] K_M_TEN       = 24'hA00000;

    // biased exponent of a value with its top bit at bit MantW-1
    localparam logic [7:0] E_TOP = 8'(127 + MantW - 1);

    // one finished number request passed from front to back
    typedef struct packed {
        logic                neg;
        logic                had;
        logic [MantW-1:0]    mant;
        logic signed [7:0]   dexp;
    } t_job;

endpackage
`default_nettype wire

// ===== rtl/dtf_front.sv =====
`default_nettype none
module dtf_front
    import dtf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_char,
    output logic            o_push,
    output t_job            o_job
);

    logic                 r_at_start, n_at_start;
    logic                 r_neg, n_neg;
    logic [MantW-1:0]     r_mant, n_mant;
    logic signed [7:0]    r_dexp, n_dexp;
    logic [CountW-1:0]    r_dcnt, n_dcnt;
    logic                 r_pseen, n_pseen;
    logic                 is_digit;
    logic [3:0]           dval;

    assign is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign dval     = 4'(i_char - CH_ZERO);

    // job handed over on a terminator
    assign o_job.neg  = r_neg;
    assign o_job.had  = (r_dcnt != '0);
    assign o_job.mant = r_mant;
    assign o_job.dexp = r_dexp;

    // character parser
    always_comb begin
        n_at_start = r_at_start;
        n_neg      = r_neg;
        n_mant     = r_mant;
        n_dexp     = r_dexp;
        n_dcnt     = r_dcnt;
        n_pseen    = r_pseen;
        o_push     = 1'b0;
        if (i_take) begin
            n_at_start = 1'b0;
            if (r_at_start && (i_char == CH_MINUS || i_char == CH_PLUS)) begin
                n_neg = (i_char == CH_MINUS);
            end else if (is_digit) begin
                if (r_dcnt < CountW'(MaxDigits)) begin
                    n_dcnt = r_dcnt + 1'b1;
                    if (r_pseen) begin
                        n_dexp = r_dexp - 8'sd1;
                    end
                    n_mant = MantW'({r_mant, 3'b000}) + MantW'({r_mant, 1'b0})
                           + MantW'(dval);
                end else begin
                    n_dcnt = CountW'(MaxDigits + 1);
                    if (!r_pseen && r_dexp < 8'sd127) begin
                        n_dexp = r_dexp + 8'sd1;
                    end
                end
            end else if (i_char == CH_DOT && !r_pseen) begin
                n_pseen = 1'b1;
            end else begin
                o_push     = 1'b1;
                n_at_start = 1'b1;
                n_neg      = 1'b0;
                n_mant     = '0;
                n_dexp     = '0;
                n_dcnt     = '0;
                n_pseen    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_neg      <= 1'b0;
            r_mant     <= '0;
            r_dexp     <= '0;
            r_dcnt     <= '0;
            r_pseen    <= 1'b0;
        end else begin
            r_at_start <= n_at_start;
            r_neg      <= n_neg;
            r_mant     <= n_mant;
            r_dexp     <= n_dexp;
            r_dcnt     <= n_dcnt;
            r_pseen    <= n_pseen;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/dtf_queue.sv =====
`default_nettype none
module dtf_queue
    import dtf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_job      o_job
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    // two-entry request queue
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/dtf_back.sv =====
`default_nettype none
module dtf_back
    import dtf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_empty,
    input  wire t_job        i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_value,
    output logic             o_had
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NORM = 3'd1;
    localparam logic [2:0] S_CRND = 3'd2;
    localparam logic [2:0] S_PICK = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_MRND = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]          r_state;
    logic [MantW-1:0]    r_w;
    logic [4:0]          r_shift;
    logic signed [7:0]   r_e;
    logic                r_neg, r_had, r_zero, r_inf;
    logic [7:0]          r_exp;
    logic [23:0]         r_man;
    logic [7:0]          r_ce;
    logic [23:0]         r_cm;
    logic [47:0]         r_prod;
    logic                r_ovalid;
    logic [31:0]         r_oval;
    logic                r_ohad;

    logic [24:0] c_round, m_round;
    logic [9:0]  m_exp;
    logic        m_top;
    logic [23:0] m_keep;
    logic        m_g, m_s;
    logic        out_free;

    assign out_free = !r_ovalid || i_ready;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign o_valid  = r_ovalid;
    assign o_value  = r_oval;
    assign o_had    = r_ohad;

    // integer to float rounding, nearest even
    assign c_round = {1'b0, r_w[MantW-1:MantW-24]}
                   + 25'(r_w[MantW-25] & ((|r_w[MantW-26:0]) | r_w[MantW-24]));

    // product rounding, nearest even
    assign m_top   = r_prod[47];
    assign m_keep  = m_top ? r_prod[47:24] : r_prod[46:23];
    assign m_g     = m_top ? r_prod[23] : r_prod[22];
    assign m_s     = m_top ? (|r_prod[22:0]) : (|r_prod[21:0]);
    assign m_round = {1'b0, m_keep} + 25'(m_g & (m_s | m_keep[0]));
    assign m_exp   = {2'b00, r_exp} + {2'b00, r_ce} - 10'd127 + 10'(m_top)
                   + 10'(m_round[24]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                // take the next request
                S_IDLE: begin
                    if (!i_empty) begin
                        r_neg   <= i_job.neg & i_job.had;
                        r_had   <= i_job.had;
                        r_w     <= i_job.mant;
                        r_e     <= i_job.dexp;
                        r_shift <= '0;
                        r_inf   <= 1'b0;
                        r_zero  <= (i_job.mant == '0);
                        r_state <= (i_job.mant == '0) ? S_DONE : S_NORM;
                    end
                end
                // one bit of normalizing shift per cycle
                S_NORM: begin
                    if (r_w[MantW-1]) begin
                        r_state <= S_CRND;
                    end else begin
                        r_w     <= {r_w[MantW-2:0], 1'b0};
                        r_shift <= r_shift + 5'd1;
                    end
                end
                S_CRND: begin
                    r_exp   <= E_TOP - 8'(r_shift) + 8'(c_round[24]);
                    r_man   <= c_round[24] ? c_round[24:1] : c_round[23:0];
                    r_state <= S_PICK;
                end
                // choose the next scale step
                S_PICK: begin
                    if (r_e <= -8'sd2) begin
                        r_ce    <= K_E_HUNDREDTH;
                        r_cm    <= K_M_HUNDREDTH;
                        r_e     <= r_e + 8'sd2;
                        r_state <= S_MUL;
                    end else if (r_e == -8'sd1) begin
                        r_ce    <= K_E_TENTH;
                        r_cm    <= K_M_TENTH;
                        r_e     <= 8'sd0;
                        r_state <= S_MUL;
                    end else if (r_e > 8'sd0) begin
                        r_ce    <= K_E_TEN;
                        r_cm    <= K_M_TEN;
                        r_e     <= r_e - 8'sd1;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_man * r_cm;
                    r_state <= r_inf ? S_PICK : S_MRND;
                end
                S_MRND: begin
                    if (m_exp >= 10'd255) begin
                        r_inf <= 1'b1;
                    end else begin
                        r_exp <= m_exp[7:0];
                        r_man <= m_round[24] ? m_round[24:1] : m_round[23:0];
                    end
                    r_state <= S_PICK;
                end
                // load the output register
                S_DONE: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ohad   <= r_had;
                        if (r_zero) begin
                            r_oval <= {r_neg, 31'd0};
                        end else if (r_inf) begin
                            r_oval <= {r_neg, 8'hFF, 23'd0};
                        end else begin
                            r_oval <= {r_neg, r_exp, r_man[22:0]};
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/decimal_text_to_float32_core.sv =====
// channel | valid       | ready       | payload
// in      | i_in_valid  | o_in_ready  | i_text_char
// out     | o_out_valid | i_out_ready | o_value_bits, o_had_digits
//
// digits, signs and points are parsed as they arrive; a terminator hands a request
// to the two-entry queue and the back end then normalizes the mantissa by shifts
// of up to 26 bits in total, rounds it and applies scale multiplies (up to 127
// by ten), each rounded until the value is infinite; a zero mantissa skips this.
// the back end has a single multiplier and takes a new request only when idle.
// reset is synchronous, active low, and clears parser, queue and output valid.
// input stalls only while the queue is full; output waits in its own register.
`default_nettype none
module decimal_text_to_float32_core
    import dtf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_text_char,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_value_bits,
    output logic             o_had_digits
);

    logic push, pop, full, empty;
    t_job job_in, job_out;

    assign o_in_ready = !full;

    dtf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (i_in_valid && !full),
        .i_char  (i_text_char),
        .o_push  (push),
        .o_job   (job_in)
    );

    dtf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (job_out)
    );

    dtf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (job_out),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_value (o_value_bits),
        .o_had   (o_had_digits)
    );

endmodule
`default_nettype wire

// ===== rtl/dtf_checker.sv =====
`default_nettype none
module dtf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] o_value_bits,
    input wire logic        o_had_digits
);

    // a result held back keeps its valid
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // a result held back keeps its payload
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_value_bits) && $stable(o_had_digits))
        else $error("result changed while stalled");

    // no digits gives plus zero
    a_nodig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_had_digits |-> o_value_bits == 32'd0)
        else $error("empty number is not plus zero");

    // never a nan
    a_nonan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_value_bits[30:23] == 8'hFF && o_value_bits[22:0] != 23'd0))
        else $error("nan produced");

    // reset leaves no result pending
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind decimal_text_to_float32_core dtf_checker u_dtf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_value_bits (o_value_bits),
    .o_had_digits (o_had_digits)
);
`default_nettype wire
